// ----- hw/rtl/mlm_pkg.sv -----
// Shared types and constants for the multiprecision limb multiplier.
// Used by mlm_ctrl, mlm_dp, multiprecision_limb_multiplier and the testbench; no dependencies.
package mlm_pkg;

    localparam int LIMB_W    = 32;
    localparam int MAX_LIMBS = 32;
    localparam int IDX_W     = $clog2(MAX_LIMBS);
    localparam int LEN_W     = 6;
    localparam int PIDX_W    = $clog2(2 * MAX_LIMBS);
    localparam int PROD_W    = 2 * LIMB_W;

    typedef enum logic
    {
        CFG_LEN_A = 1'b0,
        CFG_LEN_B = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_FETCH,
        ST_MUL,
        ST_ACC,
        ST_CARRY,
        ST_RD,
        ST_SEND
    } state_t;

    typedef struct packed
    {
        logic              a_we;
        logic [IDX_W-1:0]  a_addr;
        logic              b_we;
        logic [IDX_W-1:0]  b_addr;
        logic              fetch;
        logic [IDX_W-1:0]  j_addr;
        logic [IDX_W-1:0]  i_addr;
        logic              mul;
        logic              acc;
        logic              first_row;
        logic              carry_wr;
        logic              acc_rd;
        logic [PIDX_W-1:0] acc_addr;
    } cmd_t;

endpackage

// ----- hw/rtl/mlm_ctrl.sv -----
// Controller for the multiprecision limb multiplier: load counters, MAC sequencing
// and product emission. Depends on mlm_pkg.
module mlm_ctrl
    import mlm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [LEN_W-1:0] len_a,
    input  logic [LEN_W-1:0] len_b,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             operand_select,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             last_limb,
    output cmd_t             cmd
);

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    a_cnt_reg, a_cnt_next;
    logic [LEN_W-1:0]    b_cnt_reg, b_cnt_next;
    logic [IDX_W-1:0]    i_reg, i_next;
    logic [IDX_W-1:0]    j_reg, j_next;
    logic [PIDX_W-1:0]   k_reg, k_next;
    logic [LEN_W-1:0]    na;
    logic [LEN_W-1:0]    nb;
    logic [IDX_W-1:0]    na_m1;
    logic [IDX_W-1:0]    nb_m1;
    logic [PIDX_W-1:0]   total_m1;
    logic                in_acc;
    logic                out_acc;
    logic                b_done;

    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0)
            r = LEN_W'(1);
        else if (v > LEN_W'(MAX_LIMBS))
            r = LEN_W'(MAX_LIMBS);
        else
            r = v;
        return r;
    endfunction

    assign na       = eff_len(len_a);
    assign nb       = eff_len(len_b);
    assign na_m1    = IDX_W'(na - LEN_W'(1));
    assign nb_m1    = IDX_W'(nb - LEN_W'(1));
    assign total_m1 = PIDX_W'(na) + PIDX_W'(nb) - PIDX_W'(1);
    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;
    assign b_done   = (b_cnt_reg + LEN_W'(1)) >= nb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            a_cnt_reg <= '0;
            b_cnt_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            a_cnt_reg <= a_cnt_next;
            b_cnt_reg <= b_cnt_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        a_cnt_next = a_cnt_reg;
        b_cnt_next = b_cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (!operand_select)
                    begin
                        if (a_cnt_reg < na)
                            a_cnt_next = a_cnt_reg + LEN_W'(1);
                    end
                    else if (!b_done)
                    begin
                        b_cnt_next = b_cnt_reg + LEN_W'(1);
                    end
                    else
                    begin
                        b_cnt_next = '0;
                        a_cnt_next = '0;
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (j_reg == na_m1)
                    state_next = ST_CARRY;
                else
                begin
                    j_next     = j_reg + IDX_W'(1);
                    state_next = ST_FETCH;
                end
            end
            ST_CARRY:
            begin
                j_next = '0;
                if (i_reg == nb_m1)
                begin
                    k_next     = '0;
                    state_next = ST_RD;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = ST_FETCH;
                end
            end
            ST_RD:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_acc)
                begin
                    if (k_reg == total_m1)
                        state_next = ST_IDLE;
                    else
                    begin
                        k_next     = k_reg + PIDX_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath commands
    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        last_limb     = 1'b0;
        cmd           = '0;
        cmd.a_addr    = a_cnt_reg[IDX_W-1:0];
        cmd.b_addr    = b_cnt_reg[IDX_W-1:0];
        cmd.i_addr    = i_reg;
        cmd.j_addr    = j_reg;
        cmd.first_row = (i_reg == '0);
        cmd.acc_addr  = PIDX_W'(i_reg) + PIDX_W'(j_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.a_we = in_valid && !operand_select && (a_cnt_reg < na);
                cmd.b_we = in_valid && operand_select;
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                cmd.acc_rd = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
            end
            ST_CARRY:
            begin
                cmd.carry_wr = 1'b1;
                cmd.acc_addr = PIDX_W'(i_reg) + PIDX_W'(na);
            end
            ST_RD:
            begin
                cmd.acc_rd   = 1'b1;
                cmd.acc_addr = k_reg;
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
                last_limb = (k_reg == total_m1);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/mlm_dp.sv -----
// Datapath for the multiprecision limb multiplier: operand stores, product
// accumulator, 32x32 multiplier and carry adder. Depends on mlm_pkg.
module mlm_dp
    import mlm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    input  logic [LIMB_W-1:0] limb_value,
    output logic [LIMB_W-1:0] product_limb
);

    logic [LIMB_W-1:0] a_mem   [MAX_LIMBS];
    logic [LIMB_W-1:0] b_mem   [MAX_LIMBS];
    logic [LIMB_W-1:0] acc_mem [2*MAX_LIMBS];

    logic [LIMB_W-1:0] a_rd_reg;
    logic [LIMB_W-1:0] b_rd_reg;
    logic [LIMB_W-1:0] acc_rd_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [LIMB_W-1:0] carry_reg, carry_next;
    logic [PROD_W-1:0] sum;
    logic [LIMB_W-1:0] acc_in;

    assign acc_in     = cmd.first_row ? '0 : acc_rd_reg;
    assign sum        = prod_reg + PROD_W'(acc_in) + PROD_W'(carry_reg);
    assign carry_next = sum[PROD_W-1:LIMB_W];

    always_ff @(posedge clk)
    begin
        if (cmd.a_we)
            a_mem[cmd.a_addr] <= limb_value;
        if (cmd.b_we)
            b_mem[cmd.b_addr] <= limb_value;
        if (cmd.fetch)
        begin
            a_rd_reg <= a_mem[cmd.j_addr];
            b_rd_reg <= b_mem[cmd.i_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc)
            acc_mem[cmd.acc_addr] <= sum[LIMB_W-1:0];
        else if (cmd.carry_wr)
            acc_mem[cmd.acc_addr] <= carry_reg;
        if (cmd.acc_rd)
            acc_rd_reg <= acc_mem[cmd.acc_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            prod_reg <= PROD_W'(a_rd_reg) * PROD_W'(b_rd_reg);
    end

    // carry runs along one row and drops at its end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            carry_reg <= '0;
        else if (cmd.acc)
            carry_reg <= carry_next;
        else if (cmd.carry_wr)
            carry_reg <= '0;
    end

    assign product_limb = acc_rd_reg;

endmodule

// ----- hw/rtl/multiprecision_limb_multiplier.sv -----
// Multiprecision limb multiplier, schoolbook method over 32-bit limbs.
// Loading: one limb per cycle while idle. Product: after the last multiplier limb,
// one shared 32x32 multiply-accumulate steps fetch, multiply, accumulate per partial
// product and a carry write per row, then sends na+nb limbs from the accumulator.
// Reset: asynchronous, active low; clears control, counters and lengths (8 and 8).
// Operand and accumulator memories are not cleared.
module multiprecision_limb_multiplier
    import mlm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [LEN_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              operand_select,
    input  logic [LIMB_W-1:0] limb_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [LIMB_W-1:0] product_limb,
    output logic              last_limb
);

    logic [LEN_W-1:0] len_a_reg;
    logic [LEN_W-1:0] len_b_reg;
    cmd_t             cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg <= LEN_W'(8);
            len_b_reg <= LEN_W'(8);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LEN_A: len_a_reg <= cfg_data;
                CFG_LEN_B: len_b_reg <= cfg_data;
                default:   len_a_reg <= len_a_reg;
            endcase
        end
    end

    mlm_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .len_a          (len_a_reg),
        .len_b          (len_b_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operand_select (operand_select),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .last_limb      (last_limb),
        .cmd            (cmd)
    );

    mlm_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .limb_value   (limb_value),
        .product_limb (product_limb)
    );

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a product limb is offered");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_limb) |=> in_ready)
        else $error("not ready for items after the last product limb");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !operand_select) |=> (in_ready && !out_valid))
        else $error("multiplicand item caused work");

    a_mac_no_output: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.acc || cmd.mul || cmd.fetch || cmd.carry_wr) |-> !out_valid)
        else $error("product limb offered during multiply-accumulate");
`endif

endmodule

// ----- tb/multiprecision_limb_multiplier_test.sv -----
// Self-checking testbench for multiprecision_limb_multiplier: loads operand limbs,
// predicts every product limb with a schoolbook model and checks the output stream.
// Depends on mlm_pkg and the multiprecision_limb_multiplier RTL only.
`timescale 1ns / 1ps

module multiprecision_limb_multiplier_test;
    import mlm_pkg::*;

    typedef struct
    {
        logic [LIMB_W-1:0] limb;
        logic              last;
    } product_limb_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    cfg_index_t        cfg_index = CFG_LEN_A;
    logic [LEN_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              operand_select = 1'b0;
    logic [LIMB_W-1:0] limb_value = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [LIMB_W-1:0] product_limb;
    logic              last_limb;

    logic [LIMB_W-1:0] multiplicand_limbs [MAX_LIMBS];
    logic [LIMB_W-1:0] multiplier_limbs [MAX_LIMBS];
    bit   [MAX_LIMBS-1:0] multiplicand_loaded = '0;
    int unsigned       multiplicand_fill = 0;
    int unsigned       multiplier_fill = 0;
    logic [LEN_W-1:0]  len_a_setting = 6'd8;
    logic [LEN_W-1:0]  len_b_setting = 6'd8;

    product_limb_t     pending_limbs [$];
    int                failures = 0;
    int                loaded_items = 0;
    int                products_formed = 0;
    int                limbs_checked = 0;
    bit                steady_stretch = 1'b0;

    multiprecision_limb_multiplier dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operand_select (operand_select),
        .limb_value     (limb_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .product_limb   (product_limb),
        .last_limb      (last_limb)
    );

    always #4 clk = ~clk;

    function automatic int unsigned effective_length(input logic [LEN_W-1:0] setting);
        if (setting == 0)
            return 1;
        if (setting > MAX_LIMBS)
            return MAX_LIMBS;
        return setting;
    endfunction

    function automatic bit reads_unloaded_limb(input bit sel);
        int unsigned na;
        int unsigned nb;
        na = effective_length(len_a_setting);
        nb = effective_length(len_b_setting);
        if (!sel || multiplier_fill + 1 < nb)
            return 1'b0;
        for (int j = 0; j < na; j++)
            if (!multiplicand_loaded[j])
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void multiply_operands(input int unsigned na, input int unsigned nb);
        logic [LIMB_W-1:0] partial [2*MAX_LIMBS];
        bit   [PROD_W-1:0] t;
        bit   [PROD_W-1:0] carry;
        product_limb_t     item;
        for (int k = 0; k < 2 * MAX_LIMBS; k++)
            partial[k] = '0;
        for (int i = 0; i < nb; i++)
        begin
            carry = '0;
            for (int j = 0; j < na; j++)
            begin
                t = PROD_W'(multiplicand_limbs[j]) * PROD_W'(multiplier_limbs[i])
                    + PROD_W'(partial[i+j]) + carry;
                partial[i+j] = t[LIMB_W-1:0];
                carry = t >> LIMB_W;
            end
            partial[i+na] = carry[LIMB_W-1:0];
        end
        for (int k = 0; k < na + nb; k++)
        begin
            item.limb = partial[k];
            item.last = (k + 1 == na + nb);
            pending_limbs.push_back(item);
        end
        products_formed++;
    endfunction

    // Returns 1 when the limb changed state, 0 when the block drops it.
    function automatic bit load_limb(input bit sel, input logic [LIMB_W-1:0] value);
        int unsigned na;
        int unsigned nb;
        na = effective_length(len_a_setting);
        nb = effective_length(len_b_setting);
        if (!sel)
        begin
            if (multiplicand_fill < na && multiplicand_fill < MAX_LIMBS)
            begin
                multiplicand_limbs[multiplicand_fill] = value;
                multiplicand_loaded[multiplicand_fill] = 1'b1;
                multiplicand_fill++;
                return 1'b1;
            end
            return 1'b0;
        end
        multiplier_limbs[(multiplier_fill < MAX_LIMBS) ? multiplier_fill : MAX_LIMBS-1] = value;
        multiplier_fill++;
        if (multiplier_fill < nb)
        begin
            multiplier_fill &= 6'h3f;
            return 1'b1;
        end
        multiply_operands(na, nb);
        multiplicand_fill = 0;
        multiplier_fill = 0;
        return 1'b1;
    endfunction

    function automatic logic [LIMB_W-1:0] pick_limb();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 19))
            0: return 6'd0;
            1: return 6'd32;
            2: return 6'd33;
            3: return 6'd63;
            default: return LEN_W'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic send_limb(input bit sel, input logic [LIMB_W-1:0] value);
        bit chosen;
        chosen = sel && !reads_unloaded_limb(sel);
        if (!steady_stretch && $urandom_range(0, 99) < 6)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        operand_select <= chosen;
        limb_value <= value;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (load_limb(chosen, value))
            loaded_items++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_limbs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_length(input cfg_index_t idx, input logic [LEN_W-1:0] value);
        wait_drained();
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_LEN_A)
            len_a_setting = value;
        else
            len_b_setting = value;
    endtask

    // Top up whichever operand is short, then finish the multiplier.
    task automatic send_product();
        int unsigned na;
        int unsigned nb;
        na = effective_length(len_a_setting);
        nb = effective_length(len_b_setting);
        while (multiplicand_fill < na)
            send_limb(1'b0, pick_limb());
        for (int i = multiplier_fill; i < nb; i++)
            send_limb(1'b1, pick_limb());
    endtask

    task automatic test_reset_lengths();
        for (int j = 0; j < 8; j++)
            send_limb(1'b0, '1);
        for (int i = 0; i < 8; i++)
            send_limb(1'b1, '1);
    endtask

    task automatic test_zero_lengths();
        write_length(CFG_LEN_A, 6'd0);
        write_length(CFG_LEN_B, 6'd0);
        send_limb(1'b0, '0);
        send_limb(1'b1, '1);
    endtask

    task automatic test_surplus_multiplicand();
        write_length(CFG_LEN_A, 6'd2);
        send_limb(1'b0, 32'hdead_beef);
        send_limb(1'b0, 32'h8000_0001);
        send_limb(1'b0, 32'h1234_5678);
        send_limb(1'b1, 32'hffff_fffe);
    endtask

    task automatic test_stale_multiplicand();
        send_limb(1'b0, 32'h0000_0003);
        send_limb(1'b1, 32'h7fff_ffff);
    endtask

    task automatic test_length_change();
        write_length(CFG_LEN_B, 6'd2);
        send_limb(1'b0, 32'h5555_aaaa);
        send_limb(1'b0, 32'haaaa_5555);
        send_limb(1'b1, 32'h0f0f_f0f0);
        write_length(CFG_LEN_B, 6'd1);
        send_limb(1'b1, 32'hc001_d00d);
    endtask

    task automatic test_random_products();
        int products;
        while (loaded_items < 345)
        begin
            write_length(CFG_LEN_A, pick_length());
            write_length(CFG_LEN_B, pick_length());
            products = (effective_length(len_a_setting) > 8 ||
                        effective_length(len_b_setting) > 8) ? 1 : $urandom_range(1, 4);
            repeat (products)
            begin
                steady_stretch = (loaded_items >= 150 && loaded_items < 230);
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
                if ($urandom_range(0, 99) < 15)
                    repeat ($urandom_range(1, 6))
                        send_limb($urandom_range(0, 1), pick_limb());
                else
                    send_product();
            end
        end
        steady_stretch = 1'b0;
    endtask

    always @(posedge clk)
    begin
        product_limb_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_limbs.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected limb: expected none, actual %h last %b",
                         $time, product_limb, last_limb);
            end
            else
            begin
                want = pending_limbs.pop_front();
                limbs_checked++;
                if (product_limb !== want.limb)
                begin
                    failures++;
                    $display("%0t: product_limb mismatch: expected %h, actual %h",
                             $time, want.limb, product_limb);
                end
                if (last_limb !== want.last)
                begin
                    failures++;
                    $display("%0t: last_limb mismatch: expected %b, actual %b",
                             $time, want.last, last_limb);
                end
            end
        end
        out_ready <= steady_stretch ? 1'b1 : ($urandom_range(0, 99) >= 6);
    end

    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_lengths();
        test_zero_lengths();
        test_surplus_multiplicand();
        test_stale_multiplicand();
        test_length_change();
        test_random_products();
        wait_drained();
        repeat (200) @(posedge clk);
        $display("Loaded %0d operand limbs, formed %0d products, checked %0d product limbs",
                 loaded_items, products_formed, limbs_checked);
        $display("Reset and zero lengths, random lengths up to 63, surplus and stale limbs");
        if (failures == 0 && pending_limbs.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/mlm_pkg.sv
hw/rtl/mlm_ctrl.sv
hw/rtl/mlm_dp.sv
hw/rtl/multiprecision_limb_multiplier.sv
tb/multiprecision_limb_multiplier_test.sv
